[hdl/sorted_integer_set_core_defines.svh]
// Assertion helpers for the sorted integer set core
`ifndef SORTED_INTEGER_SET_CORE_DEFINES_SVH
`define SORTED_INTEGER_SET_CORE_DEFINES_SVH
// Check a property on every clock edge outside reset
`define SIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define SIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[hdl/sis_pkg.sv]
`default_nettype none
package sis_pkg;
  localparam int unsigned CapacityDefault = 256;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    W16 = 2'd0,
    W32 = 2'd1,
    W64 = 2'd2
  } width_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_HIT_RD,
    ST_HIT_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_POS_RD,
    ST_POS_DONE,
    ST_DONE
  } state_t;

  // Smallest width code that holds a signed value
  function automatic width_t width_of(input logic signed [63:0] v);
    logic hi32;
    logic hi16;
    hi32 = (v[63:31] != '0) && (v[63:31] != '1);
    hi16 = (v[63:15] != '0) && (v[63:15] != '1);
    if (hi32) begin
      return W64;
    end else if (hi16) begin
      return W32;
    end
    return W16;
  endfunction
endpackage
`default_nettype wire

[hdl/sorted_integer_set_core.sv]
`default_nettype none
// Sorted integer set: keeps distinct signed 64-bit values in ascending order.
// Input channel in_valid/in_stall carries operation, value and position, one
// transaction per item. Output channel out_valid/out_stall returns exactly one
// result per item: ok, read_value, count, width_code, full_res.
// Add, remove and test run a binary search through the element memory, each
// probe a read state and then a compare state; a remove or test of a value
// wider than the current width skips the search and fails. Add then shifts
// every later entry up and remove shifts them down, each moved entry read
// and then written through the one-port-read, one-port-write memory.
// A read by position reads the entry, then checks the position against count.
// One item is in work at a time; the result sits in an output register, and
// the next item is taken as soon as that register is free or being drained.
// A stalled result holds its value until taken, and no new item starts.
// Reset (rst, synchronous) empties the set and sets the width to 16 bits;
// the memory itself is not cleared, since entries past the count are unread.
module sorted_integer_set_core #(
  parameter int unsigned CAPACITY = sis_pkg::CapacityDefault
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [1:0]                        operation,
  input  wire  signed [63:0]                value,
  input  wire  [7:0]                        position,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              ok,
  output logic signed [63:0]                read_value,
  output logic [$clog2(CAPACITY+1)-1:0]     count,
  output logic [1:0]                        width_code,
  output logic                              full_res
);
  import sis_pkg::*;
  `include "sorted_integer_set_core_defines.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapFull = CW'(CAPACITY);

  // element memory
  logic signed [63:0] mem [CAPACITY];
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic signed [63:0] rd_data;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic signed [63:0] wr_data;

  state_t state, state_next;

  // item registers
  op_t                op;
  logic signed [63:0] val;
  logic [7:0]         pos;
  logic [CW-1:0]      lo, hi, idx;
  logic [CW-1:0]      elem_cnt;
  width_t             width_use;
  logic               res_ok, res_full;

  logic               accept;
  logic               out_free;
  logic [CW-1:0]      mid;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign mid      = lo + ((hi - lo) >> 1);

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(operation))
            OP_READ: state_next = ST_POS_RD;
            OP_ADD:  state_next = ST_SRCH_RD;
            default: state_next = (width_of(value) <= width_use) ? ST_SRCH_RD : ST_DONE;
          endcase
        end
      end
      ST_SRCH_RD:  state_next = (lo < hi) ? ST_SRCH_CMP : ST_HIT_RD;
      ST_SRCH_CMP: state_next = ST_SRCH_RD;
      ST_HIT_RD:   state_next = ST_HIT_CMP;
      ST_HIT_CMP: begin
        if (lo < elem_cnt && rd_data == val) begin
          state_next = (op == OP_REMOVE) ? ST_DN_RD : ST_DONE;
        end else if (op == OP_ADD && elem_cnt != CapFull) begin
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_UP_RD:    state_next = ST_UP_WR;
      ST_UP_WR:    state_next = (idx == lo) ? ST_DONE : ST_UP_RD;
      ST_DN_RD:    state_next = (idx + 1'b1 >= elem_cnt) ? ST_DONE : ST_DN_WR;
      ST_DN_WR:    state_next = ST_DN_RD;
      ST_POS_RD:   state_next = ST_POS_DONE;
      ST_POS_DONE: state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      ST_SRCH_RD: begin
        rd_en   = lo < hi;
        rd_addr = mid[AW-1:0];
      end
      ST_HIT_RD: begin
        rd_en   = lo < elem_cnt;
        rd_addr = lo[AW-1:0];
      end
      ST_UP_RD: begin
        rd_en   = idx != lo;
        rd_addr = AW'(idx - 1'b1);
      end
      ST_UP_WR: begin
        wr_en   = 1'b1;
        wr_data = (idx == lo) ? val : rd_data;
      end
      ST_DN_RD: begin
        rd_en   = idx + 1'b1 < elem_cnt;
        rd_addr = AW'(idx + 1'b1);
      end
      ST_DN_WR: wr_en = 1'b1;
      ST_POS_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      elem_cnt  <= '0;
      width_use <= W16;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
      end
      if (state == ST_UP_WR && idx == lo) begin
        elem_cnt <= elem_cnt + 1'b1;
        if (width_of(val) > width_use) begin
          width_use <= width_of(val);
        end
      end
      if (state == ST_DN_RD && idx + 1'b1 >= elem_cnt) begin
        elem_cnt <= elem_cnt - 1'b1;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op       <= op_t'(operation);
          val      <= value;
          pos      <= position;
          lo       <= '0;
          hi       <= elem_cnt;
          res_ok   <= 1'b0;
          res_full <= 1'b0;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_data < val) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      ST_HIT_CMP: begin
        idx <= (op == OP_ADD) ? elem_cnt : lo;
        if (lo < elem_cnt && rd_data == val) begin
          res_ok <= (op != OP_ADD);
        end else if (op == OP_ADD) begin
          res_ok   <= elem_cnt != CapFull;
          res_full <= elem_cnt == CapFull;
        end
      end
      ST_UP_WR:    idx <= idx - 1'b1;
      ST_DN_WR:    idx <= idx + 1'b1;
      ST_POS_DONE: res_ok <= {1'b0, pos} < {1'b0, elem_cnt};
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      ok         <= res_ok;
      read_value <= (op == OP_READ && res_ok) ? rd_data : '0;
      count      <= elem_cnt;
      width_code <= width_use;
      full_res   <= res_full;
    end
  end

  `SIS_ASSERT(a_cnt_bound, elem_cnt <= CapFull, "count above capacity")
  `SIS_ASSERT(a_one_item, accept |=> state != ST_IDLE, "item not started")
  `SIS_ASSERT(a_width_grows, width_use >= $past(width_use), "width shrank")
  `SIS_ASSERT(a_full_flag, out_valid && full_res |-> !ok && count == CapFull, "bad full")
  `SIS_ASSERT_ALWAYS(a_no_drop, out_valid && out_stall |=> out_valid || rst, "result lost")
endmodule
`default_nettype wire

[test/sorted_integer_set_core_tb.sv]
`default_nettype none
module sorted_integer_set_core_tb;
  import sis_pkg::*;

  localparam int unsigned CAP = 256;
  localparam longint unsigned CYCLE_LIMIT = 1200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = OP_ADD;
  logic signed [63:0] value = '0;
  logic [7:0] position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic signed [63:0] read_value;
  logic [8:0] count;
  logic [1:0] width_code;
  logic full_res;

  typedef struct packed {
    logic ok;
    logic signed [63:0] read_value;
    logic [8:0] count;
    logic [1:0] width_code;
    logic full_res;
  } set_result_t;

  // golden copy of the set
  logic signed [63:0] gold_elems[CAP];
  int unsigned gold_count = 0;
  logic [1:0] gold_width = W16;
  set_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  longint unsigned cycle_count = 0;
  bit long_stall_mode = 1'b0;

  sorted_integer_set_core #(.CAPACITY(CAP)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .value(value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .read_value(read_value), .count(count), .width_code(width_code),
    .full_res(full_res)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] bits_needed(logic signed [63:0] v);
    if (v < -64'sd2147483648 || v > 64'sd2147483647) return W64;
    if (v < -64'sd32768 || v > 64'sd32767) return W32;
    return W16;
  endfunction

  // lower bound search over the golden copy
  function automatic int unsigned lower_slot(logic signed [63:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = gold_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (gold_elems[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic set_result_t apply_op(logic [1:0] op, logic signed [63:0] v,
                                           logic [7:0] pos);
    set_result_t r;
    int unsigned slot;
    bit hit;
    logic [1:0] need;
    r = '0;
    need = bits_needed(v);
    slot = lower_slot(v);
    hit = (slot < gold_count) && (gold_elems[slot] == v);
    case (op)
      OP_ADD: begin
        if (!hit) begin
          if (gold_count >= CAP) begin
            r.full_res = 1'b1;
          end else begin
            for (int i = gold_count; i > slot; i--) gold_elems[i] = gold_elems[i-1];
            gold_elems[slot] = v;
            gold_count++;
            if (need > gold_width) gold_width = need;
            r.ok = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (need <= gold_width && hit) begin
          for (int i = slot; i + 1 < gold_count; i++) gold_elems[i] = gold_elems[i+1];
          gold_count--;
          r.ok = 1'b1;
        end
      end
      OP_TEST: begin
        r.ok = (need <= gold_width) && hit;
      end
      default: begin
        if (pos < gold_count) begin
          r.read_value = gold_elems[pos];
          r.ok = 1'b1;
        end
      end
    endcase
    r.count = gold_count[8:0];
    r.width_code = gold_width;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // send one transaction and queue its expected result
  task automatic send_item(logic [1:0] op, logic signed [63:0] v, logic [7:0] pos);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    value <= v;
    position <= pos;
    in_valid <= 1'b1;
    pending_results.push_back(apply_op(op, v, pos));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // values of every width class
  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'(signed'(16'($urandom())));
      1: return 64'(signed'(32'($urandom())));
      2: return rand64();
      3: return 64'(signed'($urandom_range(0, 40))) - 20;
      4: return (gold_count > 0) ? gold_elems[$urandom_range(0, gold_count - 1)] : '0;
      default: return 64'(signed'(8'($urandom())));
    endcase
  endfunction

  task automatic test_directed();
    send_item(OP_READ, 64'sd0, 8'd0);
    send_item(OP_TEST, 64'sd0, 8'd0);
    send_item(OP_REMOVE, 64'sd5, 8'd0);
    send_item(OP_ADD, 64'sd10, 8'hff);
    send_item(OP_ADD, 64'sd10, 8'd0);
    send_item(OP_ADD, -64'sd5, 8'd0);
    send_item(OP_ADD, 64'sd7, 8'd0);
    // wider value tested and removed before the width grows
    send_item(OP_TEST, 64'sd40000, 8'd0);
    send_item(OP_REMOVE, 64'sd40000, 8'd0);
    send_item(OP_ADD, 64'sd40000, 8'd0);
    send_item(OP_ADD, -64'sd3000000000, 8'd0);
    send_item(OP_ADD, 64'h7fffffffffffffff, 8'd0);
    send_item(OP_ADD, 64'h8000000000000000, 8'd0);
    send_item(OP_TEST, 64'h8000000000000000, 8'd0);
    send_item(OP_READ, 64'sd0, 8'd0);
    send_item(OP_READ, 64'sd0, 8'd6);
    send_item(OP_READ, 64'sd0, 8'd7);
    send_item(OP_READ, -64'sd1, 8'd255);
    send_item(OP_REMOVE, 64'sd7, 8'd0);
    send_item(OP_REMOVE, 64'sd7, 8'd0);
    send_item(OP_TEST, 64'sd10, 8'd0);
    send_item(OP_READ, 64'sd0, 8'd2);
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4) send_item(OP_ADD, rand_value(), 8'($urandom()));
      else if (k < 6) send_item(OP_REMOVE, rand_value(), 8'($urandom()));
      else if (k < 8) send_item(OP_TEST, rand_value(), 8'($urandom()));
      else send_item(OP_READ, rand64(),
                     $urandom_range(0, 1) ? 8'($urandom_range(0, gold_count)) : 8'($urandom()));
    end
  endtask

  // fill to capacity, hit full, read the last and first entries, then remove under long stalls
  task automatic test_full_set();
    while (gold_count < CAP) send_item(OP_ADD, rand_value() ^ 64'($urandom()), 8'd0);
    send_item(OP_ADD, 64'sd123456789012, 8'd0);
    send_item(OP_ADD, gold_elems[0], 8'd0);
    send_item(OP_READ, 64'sd0, 8'd255);
    send_item(OP_READ, 64'sd0, 8'd0);
    send_item(OP_REMOVE, gold_elems[0], 8'd0);
    send_item(OP_REMOVE, gold_elems[gold_count - 1], 8'd0);
    long_stall_mode = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_item(OP_REMOVE, gold_elems[$urandom_range(0, gold_count-1)], 8'd0);
    end
    long_stall_mode = 1'b0;
  endtask

  // drive the output stall
  always @(negedge clk) begin
    if (long_stall_mode) out_stall <= ($urandom_range(0, 3) != 0);
    else if ($urandom_range(0, 30) == 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    set_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (ok !== exp_r.ok) begin
          $error("ok exp %0d got %0d", exp_r.ok, ok); fail_count++;
        end
        if (read_value !== exp_r.read_value) begin
          $error("read_value exp %0d got %0d", exp_r.read_value, read_value); fail_count++;
        end
        if (count !== exp_r.count) begin
          $error("count exp %0d got %0d", exp_r.count, count); fail_count++;
        end
        if (width_code !== exp_r.width_code) begin
          $error("width_code exp %0d got %0d", exp_r.width_code, width_code); fail_count++;
        end
        if (full_res !== exp_r.full_res) begin
          $error("full_res exp %0d got %0d", exp_r.full_res, full_res); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(60);
    test_full_set();
    test_random_mix(100);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("covered add/remove/test/read across all widths, duplicates, full set");
    $display("%0d results checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
